// File: rtl/core/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

  // Operation requested by one input beat.
  typedef enum logic {
    ACT_PUT = 1'b0,
    ACT_GET = 1'b1
  } action_e;

  // Outcome reported with each result beat.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Sequencer states of the queue controller.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_META = 2'd1,
    S_SLOT = 2'd2,
    S_RES  = 2'd3
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] item;
    logic [4:0]  priority_req;
    logic [4:0]  min_level;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] item_out;
    logic [5:0]  served_priority;
    logic [3:0]  queue_count;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/core/mpq_meta_ram.sv
`default_nettype none

// Per-level ring descriptor memory. Each entry carries a valid bit that
// reset clears, so an entry never written since reset reads as all zeros.
module mpq_meta_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rd_data_q;

  // Valid bits mark entries written since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Storage write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; an unwritten entry reads as its reset value of zero.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/core/mpq_slot_ram.sv
`default_nettype none

// Item storage for all rings: one write port, one registered read port.
module mpq_slot_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and registered read of the item array.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/core/multilevel_priority_ready_queue.sv
// Each input beat is taken in idle; a put, or a get that finds nothing, then
// passes the descriptor and result states, a successful get also the item
// read state, set by the descriptor memory read-modify-write and the
// registered read of the item memory. No new beat is taken until the result
// is loaded for output. Reset clears the level bitmap, all descriptor valid
// bits and the output valid flag at once; the item memory is not cleared and needs no sweep.
`default_nettype none

module multilevel_priority_ready_queue #(
  parameter int unsigned LEVELS    = 32,
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned ITEM_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mpq_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mpq_pkg::out_t      out_data_o
);

  localparam int unsigned LvlW    = $clog2(LEVELS);
  localparam int unsigned IdxW    = $clog2(SLOTS);
  localparam int unsigned MetaW   = 3 * IdxW;
  localparam int unsigned SlotDep = LEVELS << IdxW;
  localparam int unsigned StoreW  = (ITEM_BITS < 16) ? ITEM_BITS : 16;

  mpq_pkg::state_e state_q, state_d;
  mpq_pkg::in_t    req_q, req_d;
  mpq_pkg::out_t   res_q, res_d;
  mpq_pkg::out_t   out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic            lvl_ok_q, lvl_ok_d;
  logic [LEVELS-1:0] nonempty_q, nonempty_d;

  logic            accept;
  logic            enc_found;
  logic [LvlW-1:0] enc_lvl;

  logic             meta_re, meta_we;
  logic [MetaW-1:0] meta_rdata, meta_wdata;
  logic [IdxW-1:0]  m_head, m_tail, m_count;
  logic [IdxW-1:0]  head_nx, tail_nx, count_inc, count_dec;

  logic                       slot_re, slot_we;
  logic [$clog2(SlotDep)-1:0] slot_raddr, slot_waddr;
  logic [StoreW-1:0]          slot_rdata;

  assign accept = in_valid_i && in_ready_o;

  // Priority encoder: lowest-numbered non-empty level at or above the minimum.
  always_comb begin
    enc_found = 1'b0;
    enc_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i] && (6'(i) >= {1'b0, in_data_i.min_level})) begin
        enc_found = 1'b1;
        enc_lvl   = LvlW'(i);
      end
    end
  end

  // Descriptor fields and their ring-pointer updates.
  assign m_head    = meta_rdata[3*IdxW-1:2*IdxW];
  assign m_tail    = meta_rdata[2*IdxW-1:IdxW];
  assign m_count   = meta_rdata[IdxW-1:0];
  assign head_nx   = (m_head == IdxW'(SLOTS - 1)) ? '0 : m_head + IdxW'(1);
  assign tail_nx   = (m_tail == IdxW'(SLOTS - 1)) ? '0 : m_tail + IdxW'(1);
  assign count_inc = m_count + IdxW'(1);
  assign count_dec = m_count - IdxW'(1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = mpq_pkg::S_META;
        end
      end
      mpq_pkg::S_META: begin
        if (req_q.action == mpq_pkg::ACT_GET && lvl_ok_q) begin
          state_d = mpq_pkg::S_SLOT;
        end else begin
          state_d = mpq_pkg::S_RES;
        end
      end
      mpq_pkg::S_SLOT: begin
        state_d = mpq_pkg::S_RES;
      end
      mpq_pkg::S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = mpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mpq_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory controls for each sequencer state.
  always_comb begin
    in_ready_o  = 1'b0;
    req_d       = req_q;
    lvl_d       = lvl_q;
    lvl_ok_d    = lvl_ok_q;
    res_d       = res_q;
    nonempty_d  = nonempty_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    meta_re     = 1'b0;
    meta_we     = 1'b0;
    meta_wdata  = meta_rdata;
    slot_re     = 1'b0;
    slot_we     = 1'b0;
    slot_raddr  = {lvl_q, m_head};
    slot_waddr  = {lvl_q, m_tail};
    case (state_q)
      mpq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        req_d      = in_data_i;
        if (in_data_i.action == mpq_pkg::ACT_PUT) begin
          lvl_ok_d = {1'b0, in_data_i.priority_req} < 6'(LEVELS);
          lvl_d    = in_data_i.priority_req[LvlW-1:0];
        end else begin
          lvl_ok_d = enc_found;
          lvl_d    = enc_lvl;
        end
        meta_re = in_valid_i && lvl_ok_d;
      end
      mpq_pkg::S_META: begin
        if (req_q.action == mpq_pkg::ACT_PUT) begin
          res_d.status          = mpq_pkg::ST_FULL;
          res_d.item_out        = '0;
          res_d.served_priority = {1'b0, req_q.priority_req};
          res_d.queue_count     = '0;
          if (lvl_ok_q && m_count >= IdxW'(SLOTS - 1)) begin
            res_d.queue_count = 4'(m_count);
          end else if (lvl_ok_q) begin
            slot_we                = 1'b1;
            meta_we                = 1'b1;
            meta_wdata             = {m_head, tail_nx, count_inc};
            nonempty_d[lvl_q]      = 1'b1;
            res_d.status           = mpq_pkg::ST_OK;
            res_d.queue_count      = 4'(count_inc);
          end
        end else begin
          res_d.status          = mpq_pkg::ST_EMPTY;
          res_d.item_out        = '0;
          res_d.served_priority = 6'(LEVELS);
          res_d.queue_count     = '0;
          if (lvl_ok_q) begin
            slot_re               = 1'b1;
            meta_we               = 1'b1;
            meta_wdata            = {head_nx, m_tail, count_dec};
            nonempty_d[lvl_q]     = (count_dec != '0);
            res_d.status          = mpq_pkg::ST_OK;
            res_d.served_priority = 6'(lvl_q);
            res_d.queue_count     = 4'(count_dec);
          end
        end
      end
      mpq_pkg::S_SLOT: begin
        res_d.item_out = 16'(slot_rdata);
      end
      mpq_pkg::S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      nonempty_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nonempty_q  <= nonempty_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    lvl_q    <= lvl_d;
    lvl_ok_q <= lvl_ok_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mpq_meta_ram #(
    .DEPTH (LEVELS),
    .WIDTH (MetaW)
  ) u_meta_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (meta_re),
    .rd_addr_i (lvl_d),
    .rd_data_o (meta_rdata),
    .wr_en_i   (meta_we),
    .wr_addr_i (lvl_q),
    .wr_data_i (meta_wdata)
  );

  mpq_slot_ram #(
    .DEPTH (SlotDep),
    .WIDTH (StoreW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .rd_en_i   (slot_re),
    .rd_addr_i (slot_raddr),
    .rd_data_o (slot_rdata),
    .wr_en_i   (slot_we),
    .wr_addr_i (slot_waddr),
    .wr_data_i (req_q.item[StoreW-1:0])
  );

  // The descriptor memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(meta_re && meta_we))
    else $error("descriptor read and write collide");

  // A new result is loaded only from the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mpq_pkg::S_RES))
    else $error("result loaded outside the result state");

  // A stored put leaves its level marked non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_we && meta_we) |=> nonempty_q[$past(lvl_q)])
    else $error("level bit not set after put");

  // A successful get always names a level that exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == mpq_pkg::ST_OK) |->
      (out_q.served_priority < 6'(LEVELS)))
    else $error("served level out of range");

endmodule

`default_nettype wire
